// ===== rtl/hsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_pkg
// Types, constants and word formats shared by the hsl to rgb converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

  // fixed point format of saturation and lightness
  localparam int FRAC_BITS = 12;
  localparam int UNIT_W    = 13;
  localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1 << FRAC_BITS);

  // hue in 1/16 degree steps
  localparam int HUE_IN_W  = 14;
  localparam int HUE_W     = 13;
  localparam int HUE_FULL  = 5760;
  localparam int HUE_SEC   = 960;
  localparam int HUE_PAIR  = 1920;
  localparam int TRI_W     = 10;

  // internal arithmetic widths
  localparam int CNUM_W    = 2 * FRAC_BITS + 1;
  localparam int LTERM_W   = UNIT_W + 11;
  localparam int K_W       = TRI_W + 2;
  localparam int PROD_W    = CNUM_W + 1 + K_W;
  localparam int V_W       = 2 * FRAC_BITS + 12;
  localparam int SUM_W     = V_W + 6;
  // channel = floor((v * 17 + 2^(2F+6)) / 2^(2F+7))
  localparam int RND_SHIFT = 2 * FRAC_BITS + 7;
  localparam int Q_W       = SUM_W - RND_SHIFT;

  // hue sector, 60 degrees each
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  // what a channel carries on top of the lightness offset
  typedef enum logic [1:0] {
    ROLE_C,
    ROLE_X,
    ROLE_Z
  } role_t;

  typedef struct packed {
    logic signed [HUE_IN_W-1:0] hue;
    logic [UNIT_W-1:0]          saturation;
    logic [UNIT_W-1:0]          lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  // shared operands handed to each channel stage
  typedef struct packed {
    logic [CNUM_W-1:0]  cnum;
    logic [TRI_W-1:0]   tri_val;
    logic [LTERM_W-1:0] lterm;
  } chan_t;

endpackage : hsl_pkg
`default_nettype wire

// ===== rtl/hsl_chan_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_chan_scale
// One color channel: weight the chroma, add the lightness offset, then scale
// to 0..255 with round half up and clamp. Three register stages.
// ----------------------------------------------------------------------------
module hsl_chan_scale (
  input  wire logic          clk,
  input  hsl_pkg::role_t     role,
  input  hsl_pkg::chan_t     chan_in,
  output logic [7:0]         level
);
  import hsl_pkg::*;

  logic signed [K_W-1:0]    k_sel;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic [LTERM_W-1:0]       lterm_r;
  logic signed [PROD_W-1:0] v_sum;
  logic [V_W-1:0]           v_nxt, v_r;
  logic [SUM_W-1:0]         rnd_sum;
  logic [Q_W-1:0]           q;
  logic [7:0]               level_nxt, level_r;

  // chroma weight per channel role, in 1/1920 units less the half chroma
  always_comb begin
    case (role)
      ROLE_C:  k_sel = K_W'(HUE_SEC);
      ROLE_X:  k_sel = $signed({1'b0, chan_in.tri_val, 1'b0}) - K_W'(HUE_SEC);
      default: k_sel = -K_W'(HUE_SEC);
    endcase
    prod_nxt = $signed({1'b0, chan_in.cnum}) * k_sel;
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    lterm_r <= chan_in.lterm;
  end

  // add lightness offset, sum is never negative
  always_comb begin
    v_sum = prod_r + $signed({{(PROD_W-LTERM_W-FRAC_BITS){1'b0}}, lterm_r,
                              {FRAC_BITS{1'b0}}});
    v_nxt = v_sum[V_W-1:0];
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  // scale by 17 / 2^(2F+7) with round half up, then clamp
  always_comb begin
    rnd_sum = SUM_W'({v_r, 4'b0000}) + SUM_W'(v_r) + (SUM_W'(1) << (RND_SHIFT - 1));
    q       = rnd_sum[SUM_W-1:RND_SHIFT];
    level_nxt = (q > Q_W'(255)) ? 8'd255 : q[7:0];
  end

  always_ff @(posedge clk) begin
    level_r <= level_nxt;
  end

  assign level = level_r;

endmodule : hsl_chan_scale
`default_nettype wire

// ===== rtl/hsl_to_rgb_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Converts one hsl color word to an 8 bit per channel rgb word.
//
//   channel  ports                     direction  handshake
//   input    start, busy, in_word      in         start && !busy
//   result   out_valid, out_word       out        strobe, one cycle
//
// One word per clock; each accepted word runs through the stages below in order.
// Stages: hue wrap and chroma base, chroma and sector, channel weight
// multiply, offset add, round and clamp. The multipliers set the stage cut.
// busy stays low: the pipeline never holds, and the receiver cannot stall.
// Reset clears the valid bits only; no state survives between words.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  hsl_pkg::hsl_in_t       in_word,
  output logic                   out_valid,
  output hsl_pkg::rgb_out_t      out_word
);
  import hsl_pkg::*;

  localparam int PIPE_DEPTH = 5;

  logic [PIPE_DEPTH-1:0] vld_nxt, vld_r;

  // stage 1 signals
  logic signed [HUE_IN_W:0] hw;
  logic [UNIT_W-1:0]        sat_c, lit_c;
  logic [UNIT_W:0]          twol, l_dev;
  logic [HUE_W-1:0]         s1_hue_nxt, s1_hue_r;
  logic [UNIT_W-1:0]        s1_sat_r, s1_lit_r;
  logic [UNIT_W-1:0]        s1_cb_nxt, s1_cb_r;

  // stage 2 signals
  logic [2*UNIT_W-1:0]      c_prod;
  logic [LTERM_W-1:0]       lterm_nxt;
  sector_t                  sector;
  logic [HUE_W-1:0]         t_val;
  logic [HUE_W-1:0]         tri_full;
  role_t                    role_r_nxt, role_g_nxt, role_b_nxt;
  role_t                    role_r_r, role_g_r, role_b_r;
  chan_t                    s2_nxt, s2_r;

  // words are accepted whenever start is high
  assign busy = 1'b0;

  // valid bits travel with the data
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: hue wrap, clamp inputs, chroma base 1 - |2l - 1|
  always_comb begin
    hw = {in_word.hue[HUE_IN_W-1], in_word.hue};
    if (hw[HUE_IN_W]) hw = hw + (HUE_IN_W+1)'(HUE_FULL);
    if (hw[HUE_IN_W]) hw = hw + (HUE_IN_W+1)'(HUE_FULL);
    if (hw >= (HUE_IN_W+1)'(HUE_FULL)) hw = hw - (HUE_IN_W+1)'(HUE_FULL);
    if (hw >= (HUE_IN_W+1)'(HUE_FULL)) hw = hw - (HUE_IN_W+1)'(HUE_FULL);
    s1_hue_nxt = hw[HUE_W-1:0];

    sat_c = (in_word.saturation > UNIT_ONE) ? UNIT_ONE : in_word.saturation;
    lit_c = (in_word.lightness > UNIT_ONE) ? UNIT_ONE : in_word.lightness;
    twol  = {lit_c, 1'b0};
    l_dev = (twol >= {1'b0, UNIT_ONE}) ? twol - {1'b0, UNIT_ONE}
                                       : {1'b0, UNIT_ONE} - twol;
    s1_cb_nxt = UNIT_ONE - l_dev[UNIT_W-1:0];
  end

  always_ff @(posedge clk) begin
    s1_hue_r <= s1_hue_nxt;
    s1_sat_r <= sat_c;
    s1_lit_r <= lit_c;
    s1_cb_r  <= s1_cb_nxt;
  end

  // stage 2: chroma, lightness term, sector and triangle position
  always_comb begin
    c_prod    = s1_cb_r * s1_sat_r;
    lterm_nxt = LTERM_W'(s1_lit_r) * LTERM_W'(HUE_PAIR);

    if (s1_hue_r < HUE_W'(HUE_SEC))           sector = SEC_RY;
    else if (s1_hue_r < HUE_W'(2 * HUE_SEC))  sector = SEC_YG;
    else if (s1_hue_r < HUE_W'(3 * HUE_SEC))  sector = SEC_GC;
    else if (s1_hue_r < HUE_W'(4 * HUE_SEC))  sector = SEC_CB;
    else if (s1_hue_r < HUE_W'(5 * HUE_SEC))  sector = SEC_BM;
    else                                      sector = SEC_MR;

    // position within a pair of sectors
    if (s1_hue_r < HUE_W'(HUE_PAIR))          t_val = s1_hue_r;
    else if (s1_hue_r < HUE_W'(2 * HUE_PAIR)) t_val = s1_hue_r - HUE_W'(HUE_PAIR);
    else                                      t_val = s1_hue_r - HUE_W'(2 * HUE_PAIR);

    tri_full = (t_val >= HUE_W'(HUE_SEC)) ? HUE_W'(HUE_PAIR) - t_val : t_val;

    s2_nxt.cnum    = c_prod[CNUM_W-1:0];
    s2_nxt.tri_val = tri_full[TRI_W-1:0];
    s2_nxt.lterm   = lterm_nxt;
  end

  // channel roles per sector
  always_comb begin
    unique case (sector)
      SEC_RY: begin
        role_r_nxt = ROLE_C; role_g_nxt = ROLE_X; role_b_nxt = ROLE_Z;
      end
      SEC_YG: begin
        role_r_nxt = ROLE_X; role_g_nxt = ROLE_C; role_b_nxt = ROLE_Z;
      end
      SEC_GC: begin
        role_r_nxt = ROLE_Z; role_g_nxt = ROLE_C; role_b_nxt = ROLE_X;
      end
      SEC_CB: begin
        role_r_nxt = ROLE_Z; role_g_nxt = ROLE_X; role_b_nxt = ROLE_C;
      end
      SEC_BM: begin
        role_r_nxt = ROLE_X; role_g_nxt = ROLE_Z; role_b_nxt = ROLE_C;
      end
      default: begin
        role_r_nxt = ROLE_C; role_g_nxt = ROLE_Z; role_b_nxt = ROLE_X;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s2_r     <= s2_nxt;
    role_r_r <= role_r_nxt;
    role_g_r <= role_g_nxt;
    role_b_r <= role_b_nxt;
  end

  // stages 3 to 5: per channel weight, offset, round and clamp
  hsl_chan_scale u_chan_red (
    .clk     (clk),
    .role    (role_r_r),
    .chan_in (s2_r),
    .level   (out_word.red)
  );

  hsl_chan_scale u_chan_green (
    .clk     (clk),
    .role    (role_g_r),
    .chan_in (s2_r),
    .level   (out_word.green)
  );

  hsl_chan_scale u_chan_blue (
    .clk     (clk),
    .role    (role_b_r),
    .chan_in (s2_r),
    .level   (out_word.blue)
  );

  assign out_valid = vld_r[PIPE_DEPTH-1];

  // every accepted word leaves as the result strobe, which follows start through the valid pipeline
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(rst_n, 5)) |-> (out_valid == $past(start, 5)))
    else $error("result strobe does not match accepted word");

  // zero saturation gives a grey result
  a_grey : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4) &&
     $past(rst_n, 5) && out_valid && ($past(in_word.saturation, 5) == '0))
    |-> (out_word.red == out_word.green && out_word.green == out_word.blue))
    else $error("grey input gave unequal channels");

  // chroma never exceeds one
  a_chroma : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (s2_r.cnum <= (CNUM_W'(1) << (2 * FRAC_BITS))))
    else $error("chroma above one");

  // triangle position stays within one sector
  a_tri : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (s2_r.tri_val <= TRI_W'(HUE_SEC)))
    else $error("secondary position out of range");

endmodule : hsl_to_rgb_converter
`default_nettype wire
